### sv/uvcpd_pkg.sv
`default_nettype none

package uvcpd_pkg;

	localparam int unsigned MAX_PACKET_BYTES = 1024;
	localparam int unsigned MIN_HEADER       = 2;
	localparam int unsigned FLAG_ERR_BIT     = 6;
	localparam int unsigned FLAG_EOF_BIT     = 1;

	localparam logic [10:0] POS_MAX   = '1;
	localparam logic [22:0] CAP_LIMIT = 23'd4194304;
	localparam logic [22:0] CAP_RESET = 23'd614400;

	typedef struct packed {
		logic [7:0]  payload_byte;
		logic        first_of_packet;
		logic        last_of_packet;
		logic [10:0] packet_length;
		logic        packet_error;
		logic        buffer_ready;
	} beat_t;

	typedef struct packed {
		logic  valid;
		beat_t beat;
	} stage_t;

endpackage

`default_nettype wire

### sv/uvcpd_in_stage.sv
`default_nettype none

module uvcpd_in_stage import uvcpd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  payload_byte,
	input  wire logic        first_of_packet,
	input  wire logic        last_of_packet,
	input  wire logic [10:0] packet_length,
	input  wire logic        packet_error,
	input  wire logic        buffer_ready,
	input  wire logic        take,
	output stage_t           s1
);

	logic  valid_s1;
	beat_t beat_s1;
	logic  accept;

	assign in_stall = valid_s1 && !take;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			beat_s1.payload_byte    <= payload_byte;
			beat_s1.first_of_packet <= first_of_packet;
			beat_s1.last_of_packet  <= last_of_packet;
			beat_s1.packet_length   <= packet_length;
			beat_s1.packet_error    <= packet_error;
			beat_s1.buffer_ready    <= buffer_ready;
		end
	end

	assign s1.valid = valid_s1;
	assign s1.beat  = beat_s1;

endmodule

`default_nettype wire

### sv/uvcpd_core.sv
`default_nettype none

module uvcpd_core import uvcpd_pkg::*; #(
	parameter int unsigned MAX_PKT_BYTES = MAX_PACKET_BYTES
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_write_en,
	input  wire logic [22:0] cfg_write_data,
	input  wire stage_t      s1,
	output logic             take,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             write_valid,
	output logic [7:0]       write_data,
	output logic [21:0]      write_offset,
	output logic             frame_done,
	output logic [22:0]      frame_bytes
);

	logic [22:0] cap_q;
	logic [10:0] byte_position_q;
	logic [7:0]  header_length_q;
	logic        eof_seen_q;
	logic        drop_q;
	logic [22:0] bytes_used_q;

	logic        out_free;
	logic        fire;
	logic [22:0] cap;
	logic [10:0] pos;
	logic [7:0]  hl;
	logic        drop_first;
	logic        drop_cur;
	logic        eof_cur;
	logic        hdr_ok;
	logic        active;
	logic        drop_n;
	logic        eof_n;
	logic        wv;
	logic        fd;
	logic [22:0] bytes_after;
	logic        has_result;
	beat_t       b;

	assign b        = s1.beat;
	assign out_free = !out_valid || !out_stall;
	assign take     = out_free;
	assign fire     = s1.valid && out_free;

	assign cap = (cap_q > CAP_LIMIT) ? CAP_LIMIT : cap_q;
	assign pos = b.first_of_packet ? 11'd0 : byte_position_q;
	assign hl  = b.first_of_packet ? b.payload_byte : header_length_q;

	assign drop_first = b.packet_error || !b.buffer_ready ||
		(b.packet_length < 11'(MIN_HEADER)) ||
		({1'b0, b.packet_length} > 12'(MAX_PKT_BYTES)) ||
		(b.payload_byte < 8'(MIN_HEADER)) ||
		({3'b000, b.payload_byte} > b.packet_length);

	assign drop_cur = b.first_of_packet ? drop_first : drop_q;
	assign eof_cur  = b.first_of_packet ? 1'b0 : eof_seen_q;
	assign hdr_ok   = hl >= 8'(MIN_HEADER);
	assign active   = hdr_ok && !drop_cur && (pos < b.packet_length);

	always_comb begin
		drop_n = drop_cur;
		eof_n  = eof_cur;
		if (active && pos == 11'd1) begin
			if (b.payload_byte[FLAG_ERR_BIT]) begin
				drop_n = 1'b1;
			end else begin
				eof_n = b.payload_byte[FLAG_EOF_BIT];
			end
		end
	end

	assign wv = active && (pos >= 11'(MIN_HEADER)) && (pos >= {3'b000, hl}) &&
		(bytes_used_q < cap);
	assign bytes_after = bytes_used_q + 23'(wv);
	assign fd = b.last_of_packet && hdr_ok && !drop_n && eof_n && (bytes_after != 23'd0);
	assign has_result = wv || fd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q           <= CAP_RESET;
			byte_position_q <= '0;
			header_length_q <= '0;
			eof_seen_q      <= 1'b0;
			drop_q          <= 1'b0;
			bytes_used_q    <= '0;
			out_valid       <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				cap_q <= cfg_write_data;
			end
			if (out_free) begin
				out_valid <= fire && has_result;
			end
			if (fire) begin
				drop_q       <= drop_n;
				bytes_used_q <= fd ? 23'd0 : bytes_after;
				if (b.last_of_packet) begin
					byte_position_q <= '0;
					header_length_q <= '0;
					eof_seen_q      <= 1'b0;
				end else begin
					byte_position_q <= (pos < POS_MAX) ? pos + 11'd1 : POS_MAX;
					header_length_q <= hl;
					eof_seen_q      <= eof_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && has_result && out_free) begin
			write_valid  <= wv;
			write_data   <= wv ? b.payload_byte : 8'd0;
			write_offset <= wv ? bytes_used_q[21:0] : 22'd0;
			frame_done   <= fd;
			frame_bytes  <= fd ? bytes_after : 23'd0;
		end
	end

endmodule

`default_nettype wire

### sv/uvc_payload_deframer_top.sv
// UVC payload deframer: takes one packet byte per beat and emits frame
// buffer writes and frame-done reports. Sustains one input beat per clock
// while the output is not stalled; a beat passes an input register and the
// single-pass header/payload logic into the result register, which drives
// the outputs. Beats that produce nothing (header bytes, dropped or
// truncated bytes) yield no output beat. Output stall backs up to in_stall
// only when both registers are full. buffer_capacity is written through
// cfg_write_en/cfg_write_data; the user must write it only while the block
// is idle, as the block itself does not enforce this.
`default_nettype none

module uvc_payload_deframer_top import uvcpd_pkg::*; #(
	parameter int unsigned MAX_PKT_BYTES = MAX_PACKET_BYTES
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_write_en,
	input  wire logic [22:0] cfg_write_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  payload_byte,
	input  wire logic        first_of_packet,
	input  wire logic        last_of_packet,
	input  wire logic [10:0] packet_length,
	input  wire logic        packet_error,
	input  wire logic        buffer_ready,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             write_valid,
	output logic [7:0]       write_data,
	output logic [21:0]      write_offset,
	output logic             frame_done,
	output logic [22:0]      frame_bytes
);

	stage_t s1;
	logic   take;

	uvcpd_in_stage u_in_stage (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.payload_byte    (payload_byte),
		.first_of_packet (first_of_packet),
		.last_of_packet  (last_of_packet),
		.packet_length   (packet_length),
		.packet_error    (packet_error),
		.buffer_ready    (buffer_ready),
		.take            (take),
		.s1              (s1)
	);

	uvcpd_core #(
		.MAX_PKT_BYTES (MAX_PKT_BYTES)
	) u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.s1             (s1),
		.take           (take),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.write_valid    (write_valid),
		.write_data     (write_data),
		.write_offset   (write_offset),
		.frame_done     (frame_done),
		.frame_bytes    (frame_bytes)
	);

`ifndef SYNTHESIS
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (s1.valid && out_valid && out_stall))
		else $error("input stalled while result register free");

	a_result_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (write_valid || frame_done))
		else $error("output beat carries neither write nor frame done");

	a_idle_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !write_valid) |-> (write_data == 8'd0 && write_offset == 22'd0))
		else $error("write fields set without write_valid");

	a_frame_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_done) |-> (frame_bytes != 23'd0))
		else $error("frame done reported for empty frame");
`endif

endmodule

`default_nettype wire

### sim/tb_uvc_payload_deframer_top.sv
module tb_uvc_payload_deframer_top import uvcpd_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned LATENCY_WAIT = 4;
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned PHASE_BEATS  = 130;
	localparam int unsigned NUM_DIRECTED = 27;
	localparam int unsigned NUM_PHASES   = 6;

	typedef struct packed {
		logic        wv;
		logic [7:0]  data;
		logic [21:0] offset;
		logic        done;
		logic [22:0] bytes;
	} fb_write_t;

	typedef struct {
		beat_t     b;
		bit        typed;
		fb_write_t res;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_write_en = 1'b0;
	logic [22:0] cfg_write_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  payload_byte = '0;
	logic        first_of_packet = 1'b0;
	logic        last_of_packet = 1'b0;
	logic [10:0] packet_length = '0;
	logic        packet_error = 1'b0;
	logic        buffer_ready = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        write_valid;
	logic [7:0]  write_data;
	logic [21:0] write_offset;
	logic        frame_done;
	logic [22:0] frame_bytes;

	// predictor state
	logic [22:0] capacity = CAP_RESET;
	logic [10:0] pkt_pos = '0;
	logic [7:0]  hdr_len = '0;
	logic        eof_seen = 1'b0;
	logic        drop_pkt = 1'b0;
	logic [22:0] frame_fill = '0;

	fb_write_t   pending_writes[$];
	stim_row_t   dir_tab [NUM_DIRECTED];
	logic [22:0] cap_plan [NUM_PHASES] = '{23'd0, 23'd3, 23'h7FFFFF, 23'd37, CAP_LIMIT, CAP_RESET};
	int unsigned beats_sent = 0;
	int unsigned mismatch_cnt = 0;
	int unsigned cycle_cnt = 0;

	uvc_payload_deframer_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.payload_byte   (payload_byte),
		.first_of_packet(first_of_packet),
		.last_of_packet (last_of_packet),
		.packet_length  (packet_length),
		.packet_error   (packet_error),
		.buffer_ready   (buffer_ready),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.write_valid    (write_valid),
		.write_data     (write_data),
		.write_offset   (write_offset),
		.frame_done     (frame_done),
		.frame_bytes    (frame_bytes)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic bit quiet_stretch();
		return beats_sent >= 400 && beats_sent < 560;
	endfunction

	function automatic beat_t pkt_byte(input logic [7:0] data, input logic first, input logic last,
			input logic [10:0] plen, input logic perr, input logic rdy);
		beat_t b;
		b.payload_byte    = data;
		b.first_of_packet = first;
		b.last_of_packet  = last;
		b.packet_length   = plen;
		b.packet_error    = perr;
		b.buffer_ready    = rdy;
		return b;
	endfunction

	function automatic fb_write_t fbw(input logic wv, input logic [7:0] data,
			input logic [21:0] offset, input logic done, input logic [22:0] bytes);
		fb_write_t r;
		r.wv     = wv;
		r.data   = data;
		r.offset = offset;
		r.done   = done;
		r.bytes  = bytes;
		return r;
	endfunction

	task automatic deframe_predict(input beat_t b, output fb_write_t r);
		logic [10:0] pos;
		logic [22:0] cap;
		r = '0;
		cap = (capacity > CAP_LIMIT) ? CAP_LIMIT : capacity;
		if (b.first_of_packet) begin
			pos      = '0;
			eof_seen = 1'b0;
			hdr_len  = b.payload_byte;
			drop_pkt = b.packet_error || !b.buffer_ready || b.packet_length < MIN_HEADER ||
				b.packet_length > MAX_PACKET_BYTES || b.payload_byte < MIN_HEADER ||
				b.payload_byte > b.packet_length;
		end else begin
			pos = pkt_pos;
		end
		if (hdr_len >= MIN_HEADER && !drop_pkt && pos < b.packet_length) begin
			if (pos == 1) begin
				if (b.payload_byte[FLAG_ERR_BIT])
					drop_pkt = 1'b1;
				else
					eof_seen = b.payload_byte[FLAG_EOF_BIT];
			end else if (pos >= 2 && pos >= hdr_len && frame_fill < cap) begin
				r.wv       = 1'b1;
				r.data     = b.payload_byte;
				r.offset   = frame_fill[21:0];
				frame_fill = frame_fill + 23'd1;
			end
		end
		if (b.last_of_packet) begin
			if (hdr_len >= MIN_HEADER && !drop_pkt && eof_seen && frame_fill != 0) begin
				r.done     = 1'b1;
				r.bytes    = frame_fill;
				frame_fill = '0;
			end
			hdr_len  = '0;
			eof_seen = 1'b0;
			pkt_pos  = '0;
		end else begin
			pkt_pos = (pos < POS_MAX) ? pos + 11'd1 : POS_MAX;
		end
	endtask

	task automatic drive_beat(input stim_row_t row);
		fb_write_t r;
		@(negedge clk);
		while (!quiet_stretch() && $urandom_range(0, 99) < 8) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid        <= 1'b1;
		payload_byte    <= row.b.payload_byte;
		first_of_packet <= row.b.first_of_packet;
		last_of_packet  <= row.b.last_of_packet;
		packet_length   <= row.b.packet_length;
		packet_error    <= row.b.packet_error;
		buffer_ready    <= row.b.buffer_ready;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		deframe_predict(row.b, r);
		if (row.typed)
			r = row.res;
		if (r.wv || r.done)
			pending_writes.push_back(r);
		beats_sent++;
	endtask

	task automatic send_packet();
		int unsigned plen, hdr, nb, pick;
		logic [7:0]  flags;
		logic        perr, rdy;
		stim_row_t   row;
		row.typed = 1'b0;
		row.res   = '0;
		if ($urandom_range(0, 99) < 6) begin
			nb = $urandom_range(1, 3);
			for (int unsigned i = 0; i < nb; i++) begin
				row.b = beat_t'($urandom);
				drive_beat(row);
			end
		end else begin
			if ($urandom_range(0, 99) < 3)
				plen = $urandom_range(25, 160);
			else
				plen = $urandom_range(2, 24);
			if ($urandom_range(0, 99) < 5)
				hdr = $urandom_range(0, 255);
			else
				hdr = $urandom_range(2, plen < 6 ? plen : 6);
			flags = 8'($urandom);
			flags[FLAG_ERR_BIT] = $urandom_range(0, 99) < 5;
			flags[FLAG_EOF_BIT] = $urandom_range(0, 99) < 35;
			perr = $urandom_range(0, 99) < 3;
			rdy  = $urandom_range(0, 99) >= 5;
			pick = $urandom_range(0, 99);
			if (pick < 8)
				nb = $urandom_range(1, plen);
			else if (pick < 13)
				nb = plen + $urandom_range(1, 4);
			else
				nb = plen;
			for (int unsigned i = 0; i < nb; i++) begin
				row.b = pkt_byte(8'($urandom), i == 0, i == nb - 1, 11'(plen), perr, rdy);
				if (i == 0)
					row.b.payload_byte = 8'(hdr);
				else if (i == 1)
					row.b.payload_byte = flags;
				drive_beat(row);
			end
		end
	endtask

	task automatic drain_and_configure(input logic [22:0] value);
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_writes.size() != 0)
			@(negedge clk);
		repeat (LATENCY_WAIT) @(negedge clk);
		cfg_write_en   <= 1'b1;
		cfg_write_data <= value;
		capacity = value;
		@(negedge clk);
		cfg_write_en <= 1'b0;
	endtask

	task automatic flag_mismatch(input string what, input fb_write_t want, input fb_write_t seen);
		if (mismatch_cnt < 10)
			$display("%s: exp wv=%0b data=%02h off=%0d done=%0b bytes=%0d,",
				what, want.wv, want.data, want.offset, want.done, want.bytes,
				" got wv=%0b data=%02h off=%0d done=%0b bytes=%0d",
				seen.wv, seen.data, seen.offset, seen.done, seen.bytes);
		mismatch_cnt++;
	endtask

	always @(negedge clk)
		out_stall <= !quiet_stretch() && ($urandom_range(0, 99) < 8);

	always @(posedge clk) begin : result_check
		fb_write_t seen, want;
		if (arst_n && out_valid && !out_stall) begin
			seen = '{write_valid, write_data, write_offset, frame_done, frame_bytes};
			if (pending_writes.size() == 0) begin
				flag_mismatch("unexpected beat", '0, seen);
			end else begin
				want = pending_writes.pop_front();
				if (seen.wv !== want.wv || seen.data !== want.data ||
					seen.offset !== want.offset || seen.done !== want.done ||
					seen.bytes !== want.bytes)
					flag_mismatch("mismatch", want, seen);
			end
		end
	end

	initial begin
		dir_tab = '{
			// stray byte after reset
			'{pkt_byte(8'h5A, 1'b0, 1'b0, 11'd4, 1'b0, 1'b1), 1'b1, '0},
			// good packet, EOF, two payload bytes
			'{pkt_byte(8'd2, 1'b1, 1'b0, 11'd4, 1'b0, 1'b1), 1'b1, '0},
			'{pkt_byte(8'h02, 1'b0, 1'b0, 11'd4, 1'b0, 1'b1), 1'b1, '0},
			'{pkt_byte(8'hFF, 1'b0, 1'b0, 11'd4, 1'b0, 1'b1), 1'b1,
				fbw(1'b1, 8'hFF, 22'd0, 1'b0, 23'd0)},
			'{pkt_byte(8'h00, 1'b0, 1'b1, 11'd4, 1'b0, 1'b1), 1'b1,
				fbw(1'b1, 8'h00, 22'd1, 1'b1, 23'd2)},
			// link error
			'{pkt_byte(8'd2, 1'b1, 1'b0, 11'd3, 1'b1, 1'b1), 1'b1, '0},
			'{pkt_byte(8'h02, 1'b0, 1'b0, 11'd3, 1'b1, 1'b1), 1'b1, '0},
			'{pkt_byte(8'hA5, 1'b0, 1'b1, 11'd3, 1'b1, 1'b1), 1'b1, '0},
			// ERR flag in header
			'{pkt_byte(8'd2, 1'b1, 1'b0, 11'd3, 1'b0, 1'b1), 1'b0, '0},
			'{pkt_byte(8'h42, 1'b0, 1'b0, 11'd3, 1'b0, 1'b1), 1'b0, '0},
			'{pkt_byte(8'h11, 1'b0, 1'b1, 11'd3, 1'b0, 1'b1), 1'b1, '0},
			// no buffer queued
			'{pkt_byte(8'd2, 1'b1, 1'b0, 11'd3, 1'b0, 1'b0), 1'b1, '0},
			'{pkt_byte(8'h33, 1'b0, 1'b1, 11'd3, 1'b0, 1'b0), 1'b1, '0},
			// header longer than packet
			'{pkt_byte(8'hFF, 1'b1, 1'b0, 11'd3, 1'b0, 1'b1), 1'b1, '0},
			'{pkt_byte(8'h02, 1'b0, 1'b0, 11'd3, 1'b0, 1'b1), 1'b1, '0},
			'{pkt_byte(8'h77, 1'b0, 1'b1, 11'd3, 1'b0, 1'b1), 1'b1, '0},
			// packet shorter than two bytes
			'{pkt_byte(8'd2, 1'b1, 1'b1, 11'd1, 1'b0, 1'b1), 1'b1, '0},
			// packet length over max
			'{pkt_byte(8'd2, 1'b1, 1'b0, 11'h7FF, 1'b0, 1'b1), 1'b1, '0},
			'{pkt_byte(8'h02, 1'b0, 1'b1, 11'h7FF, 1'b0, 1'b1), 1'b1, '0},
			// ends before the flag byte
			'{pkt_byte(8'd2, 1'b1, 1'b1, 11'd2, 1'b0, 1'b1), 1'b1, '0},
			// header length below two
			'{pkt_byte(8'd1, 1'b1, 1'b0, 11'd4, 1'b0, 1'b1), 1'b1, '0},
			'{pkt_byte(8'h02, 1'b0, 1'b1, 11'd4, 1'b0, 1'b1), 1'b1, '0},
			// extra header byte, then a byte past the declared length
			'{pkt_byte(8'd3, 1'b1, 1'b0, 11'd4, 1'b0, 1'b1), 1'b1, '0},
			'{pkt_byte(8'h02, 1'b0, 1'b0, 11'd4, 1'b0, 1'b1), 1'b1, '0},
			'{pkt_byte(8'hC3, 1'b0, 1'b0, 11'd4, 1'b0, 1'b1), 1'b0, '0},
			'{pkt_byte(8'h80, 1'b0, 1'b0, 11'd4, 1'b0, 1'b1), 1'b1,
				fbw(1'b1, 8'h80, 22'd0, 1'b0, 23'd0)},
			'{pkt_byte(8'h55, 1'b0, 1'b1, 11'd4, 1'b0, 1'b1), 1'b1,
				fbw(1'b0, 8'h00, 22'd0, 1'b1, 23'd1)}
		};

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int unsigned i = 0; i < NUM_DIRECTED; i++)
			drive_beat(dir_tab[i]);

		for (int unsigned p = 0; p < NUM_PHASES; p++) begin : phase
			int unsigned start;
			drain_and_configure(cap_plan[p]);
			start = beats_sent;
			while (beats_sent - start < PHASE_BEATS)
				send_packet();
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_writes.size() != 0)
			@(negedge clk);
		repeat (2 * LATENCY_WAIT) @(negedge clk);
		if (mismatch_cnt == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
